// File: design/skf_pkg.sv
// Shared constants for the scalar Kalman filter core.
// No dependencies; imported by the divider, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;
    localparam int VAL_W     = 32;                 // estimate / measurement
    localparam int NOISE_W   = 31;                 // noise registers
    localparam int DEN_W     = VAL_W + 2;          // variance + noise, exact
    localparam int QUO_W     = GAIN_BITS + 1;      // gain can reach 1.0 before clipping
    localparam int CNT_W     = $clog2(QUO_W + 1);

    localparam logic [VAL_W-1:0]     VAR_ONE  = VAL_W'(1) << FRAC_BITS;
    localparam logic [GAIN_BITS:0]   GAIN_ONE = (GAIN_BITS+1)'(1) << GAIN_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_INIT_EST   = 2'd0;
    localparam logic [1:0] CFG_PROC_NOISE = 2'd1;
    localparam logic [1:0] CFG_MEAS_NOISE = 2'd2;

endpackage

// File: design/scalar_kalman_filter_core.sv
// Scalar Kalman filter core, signed Q16.16 estimate, one measurement per item.
// The gain divider works out the gain one bit a cycle, then two passes go through the shared
// multiplier. The input takes no new item until the last result has entered the output
// register, so a stall on the result side holds the input. Synchronous active-low reset
// restores the register defaults, estimate 0 and variance 1.0. Uses skf_pkg, skf_div.
`timescale 1ns / 1ps

module scalar_kalman_filter_core
    import skf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [VAL_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [VAL_W-1:0] s_measurement,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [VAL_W-1:0] m_estimate
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam int PROD_W = DEN_W + GAIN_BITS + 2;
    localparam int SHR_W  = PROD_W - GAIN_BITS;

    logic [2:0]               state_reg, state_next;
    logic [NOISE_W-1:0]       pnoise_reg, mnoise_reg;
    logic signed [VAL_W-1:0]  est_reg;
    logic [VAL_W-1:0]         var_reg;
    logic signed [VAL_W-1:0]  meas_reg;
    logic [VAL_W-1:0]         p_reg;
    logic                     den_zero_reg;
    logic [GAIN_BITS-1:0]     gain_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     m_valid_reg;
    logic signed [VAL_W-1:0]  m_estimate_reg;

    logic                     accept;
    logic [VAL_W:0]           p_sum;
    logic [VAL_W-1:0]         p_sat;
    logic [DEN_W-1:0]         den;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic signed [DEN_W-1:0]  diff;
    logic signed [DEN_W-1:0]  mul_a;
    logic signed [GAIN_BITS+1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [SHR_W-1:0]  rnd_shr;
    logic signed [SHR_W-1:0]  est_wide;
    logic signed [VAL_W-1:0]  est_sat;
    logic [VAL_W-1:0]         var_sat;
    logic                     out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // predicted variance, saturating, and the exact gain denominator
    assign p_sum = {1'b0, var_reg} + (VAL_W+1)'(pnoise_reg);
    assign p_sat = p_sum[VAL_W] ? '1 : p_sum[VAL_W-1:0];
    assign den   = DEN_W'(p_sat) + DEN_W'(mnoise_reg);

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .num     (p_sat),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // shared multiplier: innovation * gain, then variance * (1 - gain)
    assign diff = DEN_W'(meas_reg) - DEN_W'(est_reg);
    always_comb begin
        if (state_reg == ST_MUL1) begin
            mul_a = diff;
            mul_b = $signed({2'b00, gain_reg});
        end else begin
            mul_a = $signed(DEN_W'(p_reg));
            mul_b = $signed({1'b0, GAIN_ONE - (GAIN_BITS+1)'(gain_reg)});
        end
    end
    assign mul_p = mul_a * mul_b;

    // round half up, shared by both products
    assign rnd_sum  = prod_reg + PROD_W'(GAIN_ONE >> 1);
    assign rnd_shr  = rnd_sum[PROD_W-1:GAIN_BITS];
    assign est_wide = SHR_W'(est_reg) + rnd_shr;

    always_comb begin
        if (est_wide[SHR_W-1:VAL_W-1] == '0 || est_wide[SHR_W-1:VAL_W-1] == '1)
            est_sat = est_wide[VAL_W-1:0];
        else if (est_wide[SHR_W-1])
            est_sat = {1'b1, {(VAL_W-1){1'b0}}};
        else
            est_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end

    assign var_sat = (rnd_shr[SHR_W-1:VAL_W] != '0) ? '1 : rnd_shr[VAL_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pnoise_reg  <= NOISE_W'(655);
            mnoise_reg  <= NOISE_W'(65536);
            est_reg     <= '0;
            var_reg     <= VAR_ONE;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_INIT_EST: begin
                        est_reg <= $signed(cfg_data);
                        var_reg <= VAR_ONE;
                    end
                    CFG_PROC_NOISE: pnoise_reg <= cfg_data[NOISE_W-1:0];
                    CFG_MEAS_NOISE: mnoise_reg <= cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_MUL2)
                est_reg <= est_sat;
            if (state_reg == ST_FIN && out_free)
                var_reg <= var_sat;
        end
        if (accept) begin
            meas_reg     <= s_measurement;
            p_reg        <= p_sat;
            den_zero_reg <= (den == '0);
        end
        if (state_reg == ST_DIV && div_done) begin
            if (den_zero_reg)
                gain_reg <= '0;
            else if (div_quo[QUO_W-1])
                gain_reg <= GAIN_MAX;
            else
                gain_reg <= div_quo[GAIN_BITS-1:0];
        end
        if (state_reg == ST_MUL1 || state_reg == ST_MUL2)
            prod_reg <= mul_p;
        if (state_reg == ST_FIN && out_free)
            m_estimate_reg <= est_reg;
    end

    assign m_valid    = m_valid_reg;
    assign m_estimate = m_estimate_reg;

endmodule

// File: design/skf_div.sv
// Restoring divider for the filter gain: floor(num * 2^GAIN_BITS / den), num <= den.
// One quotient bit per cycle; depends on skf_pkg.
`timescale 1ns / 1ps

module skf_div
    import skf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [VAL_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             first_reg, first_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // first step compares num itself (integer bit of the gain), later steps shift
    assign trial = first_reg ? rem_reg : {rem_reg[DEN_W-1:0], 1'b0};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = (DEN_W+1)'(num);
            quo_next   = '0;
            cnt_next   = CNT_W'(QUO_W);
            first_next = 1'b1;
        end else if (cnt_reg != '0) begin
            rem_next   = fits ? trial - {1'b0, den_reg} : trial;
            quo_next   = {quo_reg[QUO_W-2:0], fits};
            cnt_next   = cnt_reg - CNT_W'(1);
            first_next = 1'b0;
            done_next  = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        first_reg <= first_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: design/skf_checker.sv
// Port-level checks for scalar_kalman_filter_core, bound to the top level.
// Depends on skf_pkg for widths.
`timescale 1ns / 1ps

module skf_checker
    import skf_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [VAL_W-1:0] m_estimate
);

    // an accepted item keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened too soon after an item");

    // no result can appear right after an accept with the output empty
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared without work");

    // a waiting result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_estimate))
        else $error("result dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left the block busy");

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_estimate (m_estimate)
);

// File: tb/tb_scalar_kalman_filter_core.sv
// Self-checking testbench for scalar_kalman_filter_core: predicts each filtered estimate
// in fixed point and checks it against the core under random handshake stalls.
// Depends on skf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter_core;
    import skf_pkg::*;

    localparam int         PIPE_LAT    = 21;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [1:0] CFG_SPARE   = 2'd3;    // unmapped register index
    localparam longint     EST_MAX     = 2147483647;
    localparam longint     EST_MIN     = -longint'(2147483647) - 1;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [1:0]              cfg_index;
    logic [VAL_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_measurement;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VAL_W-1:0] m_estimate;

    // filter state mirrored in the testbench
    longint      filt_est;
    logic [63:0] filt_var;
    logic [63:0] noise_proc;
    logic [63:0] noise_meas;

    logic signed [VAL_W-1:0] expected_estimates[$];

    int n_accepted;
    int n_checked;
    int n_writes;
    int n_errors;
    int idle_cycles;
    bit send_no_idle;
    bit recv_no_idle;
    int recv_hold_len;

    scalar_kalman_filter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_measurement (s_measurement),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // one filter step: predict, gain, update estimate and variance
    function automatic logic signed [VAL_W-1:0] filter_step(
        input logic signed [VAL_W-1:0] meas);
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] gain;
        longint      diff;
        longint      nxt;
        p = filt_var + noise_proc;
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        den = p + noise_meas;
        if (den == 0) begin
            gain = 0;
        end else begin
            gain = (p << GAIN_BITS) / den;
            if (gain > 64'(GAIN_MAX))
                gain = 64'(GAIN_MAX);
        end
        diff = longint'(meas) - filt_est;
        // halves round up, so an arithmetic shift of the biased product
        nxt = filt_est + ((diff * longint'(gain) + 32768) >>> GAIN_BITS);
        if (nxt > EST_MAX)
            nxt = EST_MAX;
        if (nxt < EST_MIN)
            nxt = EST_MIN;
        p = (p * (64'(GAIN_ONE) - gain) + 64'd32768) >> GAIN_BITS;
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        filt_var = p;
        filt_est = nxt;
        return nxt[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] pick_noise();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom_range(0, 262144);
            3: v = $urandom_range(0, 16777216);
            default: v = $urandom;
        endcase
        v[VAL_W-1] = 1'($urandom_range(0, 1));    // upper bit is dropped by the core
        return v;
    endfunction

    // mostly samples scattered around a level, now and then a wild one
    function automatic logic signed [VAL_W-1:0] noisy_sample(
        input logic signed [VAL_W-1:0] centre);
        logic [VAL_W-1:0] up;
        logic [VAL_W-1:0] down;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        up   = $urandom >> $urandom_range(8, 30);
        down = $urandom >> $urandom_range(8, 30);
        return centre + up - down;
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [VAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INIT_EST: begin
                filt_est = longint'(signed'(data));
                filt_var = 64'(VAR_ONE);
            end
            CFG_PROC_NOISE: noise_proc = 64'(data[NOISE_W-1:0]);
            CFG_MEAS_NOISE: noise_meas = 64'(data[NOISE_W-1:0]);
            default: ;
        endcase
        n_writes++;
        @(posedge aclk);
    endtask

    task automatic send_measurement(input logic signed [VAL_W-1:0] meas);
        int gap;
        bit taken;
        gap = send_no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_measurement <= meas;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // drop valid and wait until every estimate has come back
    task automatic end_phase();
        s_valid <= 1'b0;
        while (expected_estimates.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_reset_state();
        send_measurement(32'sh0000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(-32'sd1);
        send_measurement(32'sd1);
        end_phase();
    endtask

    task automatic test_signed_extremes();
        cfg_write(CFG_MEAS_NOISE, 32'h0);
        cfg_write(CFG_INIT_EST, 32'h7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        end_phase();
        cfg_write(CFG_INIT_EST, 32'h8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        end_phase();
    endtask

    // no noise at all: gain clips below one, variance collapses, then 0/0
    task automatic test_gain_clip_zero_den();
        cfg_write(CFG_PROC_NOISE, 32'h0);
        cfg_write(CFG_MEAS_NOISE, 32'h0);
        cfg_write(CFG_INIT_EST, 32'h1234_5678);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(-32'sh1234_5678);
        send_measurement(32'sh0000_0000);
        send_measurement(32'sh0001_0000);
        end_phase();
    endtask

    task automatic test_variance_ceiling();
        cfg_write(CFG_PROC_NOISE, 32'hFFFF_FFFF);
        cfg_write(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
        cfg_write(CFG_INIT_EST, 32'h0);
        repeat (2) begin
            send_measurement(32'sh8000_0000);
            send_measurement(32'sh7FFF_FFFF);
        end
        send_measurement(32'sh0000_0000);
        end_phase();
    endtask

    task automatic test_unknown_register();
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE, $urandom);
        repeat (3) send_measurement($urandom);
        end_phase();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic signed [VAL_W-1:0] centre;
        repeat (phases) begin
            send_no_idle = ($urandom_range(0, 3) == 0);
            recv_no_idle = ($urandom_range(0, 3) == 0);
            cfg_write(CFG_PROC_NOISE, pick_noise());
            cfg_write(CFG_MEAS_NOISE, pick_noise());
            if ($urandom_range(0, 1))
                cfg_write(CFG_INIT_EST, $urandom);
            centre = $urandom;
            repeat (per_phase) send_measurement(noisy_sample(centre));
            end_phase();
        end
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
    endtask

    // result side stalls for a long stretch while items keep coming
    task automatic test_output_backpressure();
        logic signed [VAL_W-1:0] centre;
        centre        = $urandom;
        send_no_idle  = 1'b1;
        recv_hold_len = HOLD_CYCLES;
        repeat (60) send_measurement(noisy_sample(centre));
        end_phase();
        send_no_idle = 1'b0;
    endtask

    task automatic test_input_pause();
        logic signed [VAL_W-1:0] centre;
        centre = $urandom;
        repeat (4) begin
            repeat (10) send_measurement(noisy_sample(centre));
            end_phase();
        end
    endtask

    // result sink with per-item stalls
    initial begin : result_sink
        int stall;
        bit got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (recv_hold_len > 0) begin
                stall         = recv_hold_len;
                recv_hold_len = 0;
            end else begin
                stall = recv_no_idle ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_valid;
                @(posedge aclk);
            end while (!got);
        end
    end

    // sampled mid-cycle: handshakes seen here complete at the next rising edge
    always @(negedge aclk) begin : estimate_check
        logic signed [VAL_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_estimates.size() == 0) begin
                    $error("estimate: expected nothing, actual %0d", m_estimate);
                    n_errors++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (m_estimate !== want) begin
                        $error("estimate: expected %0d, actual %0d", want, m_estimate);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (s_valid && s_ready) begin
                expected_estimates.push_back(filter_step(s_measurement));
                n_accepted++;
            end
        end
    end

    always @(negedge aclk) begin : watchdog
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_scalar_kalman_filter_core: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_INIT_EST;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_measurement <= '0;
        filt_est      = 0;
        filt_var      = 64'(VAR_ONE);
        noise_proc    = 64'd655;
        noise_meas    = 64'd65536;
        n_accepted    = 0;
        n_checked     = 0;
        n_writes      = 0;
        n_errors      = 0;
        idle_cycles   = 0;
        send_no_idle  = 1'b0;
        recv_no_idle  = 1'b0;
        recv_hold_len = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_signed_extremes();
        test_gain_clip_zero_den();
        test_variance_ceiling();
        test_unknown_register();
        test_random_phases(10, 100);
        test_output_backpressure();
        test_input_pause();

        end_phase();
        repeat (PIPE_LAT + 10) @(posedge aclk);
        $display("Run covered %0d measurements and %0d estimates across %0d register writes,",
                 n_accepted, n_checked, n_writes);
        $display("incl. signed extremes, clipped gain, zero denominator and long output stalls");
        if (n_errors == 0)
            $display("tb_scalar_kalman_filter_core: PASS");
        else
            $display("tb_scalar_kalman_filter_core: FAIL");
        $finish;
    end

endmodule

// File: scalar_kalman_filter_core.f
design/skf_pkg.sv
design/skf_div.sv
design/scalar_kalman_filter_core.sv
design/skf_checker.sv
tb/tb_scalar_kalman_filter_core.sv
